>>> rtl/pnm_pkg.sv
// Shared types, constants and helpers of the portable anymap stream decoder.
`timescale 1ns / 1ps
package pnm_pkg;

  localparam int unsigned MaxDimDefault    = 4096;
  localparam int unsigned MaxSampleDefault = 65535;

  // Result kinds.
  localparam logic [2:0] KIND_SAMPLE  = 3'd0;
  localparam logic [2:0] KIND_MAGIC   = 3'd1;
  localparam logic [2:0] KIND_SYNTAX  = 3'd2;
  localparam logic [2:0] KIND_RANGE   = 3'd3;
  localparam logic [2:0] KIND_EOF     = 3'd4;
  localparam logic [2:0] KIND_COLOR   = 3'd5;

  // Characters the parser looks for.
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // Integer parse stages.
  localparam logic [1:0] NUM_SKIP  = 2'd0;
  localparam logic [1:0] NUM_SIGN  = 2'd1;
  localparam logic [1:0] NUM_DIGIT = 2'd2;

  // Request to the divider and its answer.
  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } div_rsp_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13) || (c == 8'd0);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> rtl/pnm_divider.sv
// Restoring radix-2 divider that yields the low 8 bits of a 24-bit by 16-bit quotient.
`timescale 1ns / 1ps
module pnm_divider import pnm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [23:0] quot_q, quot_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] trial;
  logic [16:0] shifted;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[15:0], quot_q[23]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 5'd23;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_d = trial;
      end else begin
        rem_d = shifted;
      end
      quot_d = {quot_q[22:0], ~trial[16]};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q[7:0];

endmodule

>>> rtl/pnm_stream_decoder.sv
// Top level of the portable anymap stream decoder.
`timescale 1ns / 1ps
// Each header and text byte is accepted in the idle state, then parsed in the parse state. A result
// is held in an output register until it is taken, and a new byte is accepted only while that
// register is free or, after a halt, always. Gray and color samples go through the shared serial
// divider: each sample is parsed, divided in the divide state and loaded out from the wait state.
// A raw bitmap byte gives up to eight results, one per cycle as the output drains.
// Reset is asynchronous and active low; it returns the parser to the magic letter.
module pnm_stream_decoder import pnm_pkg::*; #(
  parameter int unsigned MAX_DIM          = MaxDimDefault,
  parameter int unsigned MAX_SAMPLE_VALUE = MaxSampleDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind_o,
  output logic [7:0]  sample_o,
  output logic        last_sample_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o,
  output logic        is_color_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PARSE = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_BITS  = 6'b010000,
    ST_STOP  = 6'b100000
  } state_e;

  localparam logic [3:0] PH_MAGIC = 4'd0, PH_DIGIT = 4'd1, PH_WIDTH = 4'd2,
    PH_HEIGHT = 4'd3, PH_MAXVAL = 4'd4, PH_TBITS = 4'd5, PH_RBITS = 4'd6,
    PH_TMAP = 4'd7, PH_RMAP = 4'd8;

  localparam logic [31:0] MaxDimC = 32'(MAX_DIM);
  localparam logic [31:0] MaxSmpC = 32'(MAX_SAMPLE_VALUE);

  state_e      st_q, st_d;
  logic [3:0]  ph_q, ph_d;
  logic [2:0]  fmt_q, fmt_d;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        cmt_q, cmt_d;
  logic [1:0]  nst_q, nst_d;
  logic [12:0] wid_q, wid_d, hgt_q, hgt_d, col_q, col_d;
  logic [15:0] maxv_q, maxv_d;
  logic [25:0] left_q, left_d;
  logic        mask_q;
  logic [7:0]  byte_q, byte_d;
  logic        eof_q, eof_d;
  logic [3:0]  nbits_q, nbits_d, bidx_q, bidx_d;
  logic        pend_q, pend_d;           // end-of-file error follows the sample
  logic        ov_q, ov_d;
  logic [2:0]  okind_q, okind_d;
  logic [7:0]  osmp_q, osmp_d;
  logic        olast_q, olast_d;
  logic [15:0] dval_q, dval_d;           // value to scale

  div_req_t dreq;
  div_rsp_t drsp;

  pnm_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic out_free;
  logic color;
  assign out_free = !ov_q || !out_stall;
  assign color    = (fmt_q == 3'd3) || (fmt_q == 3'd6);

  // Header integer helpers; prod is the accumulator times ten plus the new digit.
  logic [31:0] lim, d32;
  logic [35:0] prod;
  logic [12:0] wrem;
  always_comb begin
    d32  = {24'd0, byte_q - CH_ZERO};
    lim  = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
    prod = 36'({acc_q, 3'b0}) + 36'({acc_q, 1'b0}) + {4'd0, d32};
    wrem = wid_q - col_q;
  end

  function automatic logic val_ok(input logic [31:0] v, input logic n, input logic [31:0] hi);
    return !(n && v != 0) && v >= 32'd1 && v <= hi;
  endfunction

  always_comb begin
    logic [1:0]  r;
    logic        done_num, rdy, fail_now, open_cmt;
    logic [2:0]  fk;
    logic [25:0] tot;
    st_d = st_q; ph_d = ph_q; fmt_d = fmt_q; acc_d = acc_q; neg_d = neg_q;
    cmt_d = cmt_q; nst_d = nst_q; wid_d = wid_q; hgt_d = hgt_q; col_d = col_q;
    maxv_d = maxv_q; left_d = left_q; byte_d = byte_q; eof_d = eof_q;
    nbits_d = nbits_q; bidx_d = bidx_q; pend_d = pend_q; dval_d = dval_q;
    ov_d = ov_q && out_stall; okind_d = okind_q; osmp_d = osmp_q; olast_d = olast_q;
    dreq = '0;
    r = 2'd0; done_num = 1'b0; rdy = 1'b0; fail_now = 1'b0; fk = KIND_SAMPLE;
    open_cmt = 1'b0;
    tot = 26'(({13'd0, wid_q} * {13'd0, hgt_q}) * (color ? 26'd3 : 26'd1));

    // Shared integer step on the parsed byte: r = 0 more, 1 done, 2 error.
    if (st_q == ST_PARSE) begin
      if (nst_q == NUM_SKIP) begin
        if (eof_q) r = 2'd2;
        else if (is_space(byte_q)) r = 2'd0;
        else if (byte_q == CH_HASH) open_cmt = 1'b1;
        else if (byte_q == CH_MINUS) begin neg_d = 1'b1; nst_d = NUM_SIGN; end
        else if (is_digit(byte_q)) begin neg_d = 1'b0; acc_d = d32; nst_d = NUM_DIGIT; end
        else r = 2'd2;
      end else if (nst_q == NUM_SIGN) begin
        if (!eof_q && is_digit(byte_q)) begin acc_d = d32; nst_d = NUM_DIGIT; end
        else r = 2'd2;
      end else begin
        if (!eof_q && is_digit(byte_q)) begin
          if (prod > {4'd0, lim}) r = 2'd2;
          else acc_d = prod[31:0];
        end else begin
          if (!eof_q && byte_q == CH_HASH) open_cmt = 1'b1;
          nst_d = NUM_SKIP;
          r = 2'd1;
        end
      end
    end

    case (st_q)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          byte_d = data_byte_i; eof_d = end_of_file_i; st_d = ST_PARSE;
        end
      end
      ST_PARSE: begin
        st_d = ST_IDLE;
        if (cmt_q && !eof_q) begin
          if (byte_q == CH_LF || byte_q == CH_CR) cmt_d = 1'b0;
          nst_d = nst_q; acc_d = acc_q; neg_d = neg_q;
        end else begin
          cmt_d = 1'b0;
          case (ph_q)
            PH_MAGIC: begin
              nst_d = nst_q; acc_d = acc_q; neg_d = neg_q;
              if (eof_q || byte_q != CH_P) begin fail_now = 1'b1; fk = KIND_MAGIC; end
              else ph_d = PH_DIGIT;
            end
            PH_DIGIT: begin
              nst_d = NUM_SKIP; acc_d = acc_q; neg_d = neg_q;
              if (eof_q || byte_q < CH_ONE || byte_q > CH_SIX) begin
                fail_now = 1'b1; fk = KIND_MAGIC;
              end else begin
                fmt_d = 3'(byte_q - CH_ZERO);
                if (mask_q && (fmt_d == 3'd3 || fmt_d == 3'd6)) begin
                  fail_now = 1'b1; fk = KIND_COLOR;
                end else ph_d = PH_WIDTH;
              end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
              cmt_d = open_cmt;
              if (r == 2'd2) begin fail_now = 1'b1; fk = KIND_SYNTAX; end
              else begin
                if (r == 2'd1) begin
                  if (ph_q == PH_MAXVAL ? !val_ok(acc_q, neg_q, MaxSmpC)
                                        : !val_ok(acc_q, neg_q, MaxDimC)) begin
                    fail_now = 1'b1; fk = KIND_SYNTAX;
                  end else if (ph_q == PH_WIDTH) begin
                    wid_d = acc_q[12:0]; ph_d = PH_HEIGHT;
                  end else begin
                    if (ph_q == PH_HEIGHT) hgt_d = acc_q[12:0];
                    else maxv_d = acc_q[15:0];
                    if (ph_q == PH_HEIGHT && fmt_q != 3'd1 && fmt_q != 3'd4)
                      ph_d = PH_MAXVAL;
                    else begin
                      done_num = 1'b1;
                      col_d = '0;
                      case (fmt_q)
                        3'd1:       ph_d = PH_TBITS;
                        3'd4:       ph_d = PH_RBITS;
                        3'd2, 3'd3: ph_d = PH_TMAP;
                        default:    ph_d = PH_RMAP;
                      endcase
                    end
                  end
                end
                if (!fail_now && eof_q) begin
                  fail_now = 1'b1; fk = done_num ? KIND_EOF : KIND_SYNTAX;
                end
              end
              if (done_num) begin
                left_d = (ph_q == PH_HEIGHT)
                  ? 26'(({13'd0, hgt_d} * {13'd0, wid_q}) * (color ? 26'd3 : 26'd1)) : tot;
              end
            end
            PH_TBITS: begin
              nst_d = nst_q; acc_d = acc_q; neg_d = neg_q;
              if (eof_q) begin fail_now = 1'b1; fk = KIND_EOF; end
              else if (byte_q == CH_ONE || byte_q == CH_ZERO) begin
                rdy = 1'b1; osmp_d = (byte_q == CH_ONE) ? 8'd0 : 8'd255;
              end
            end
            PH_RBITS: begin
              nst_d = nst_q; acc_d = acc_q; neg_d = neg_q;
              if (eof_q) begin fail_now = 1'b1; fk = KIND_EOF; end
              else begin
                nbits_d = (wrem > 13'd8) ? 4'd8 : wrem[3:0];
                bidx_d  = 4'd0;
                col_d   = (col_q + 13'(nbits_d) >= wid_q) ? 13'd0 : col_q + 13'(nbits_d);
                st_d    = ST_BITS;
              end
            end
            PH_RMAP: begin
              nst_d = nst_q; acc_d = acc_q; neg_d = neg_q;
              if (eof_q) begin fail_now = 1'b1; fk = KIND_EOF; end
              else begin dval_d = {8'd0, byte_q}; pend_d = 1'b0; st_d = ST_DIV; end
            end
            default: begin // text map
              cmt_d = open_cmt;
              if (eof_q && nst_q != NUM_DIGIT) begin
                fail_now = 1'b1; fk = KIND_EOF; acc_d = acc_q; nst_d = nst_q;
              end else if (r == 2'd2) begin fail_now = 1'b1; fk = KIND_RANGE; end
              else if (r == 2'd1) begin
                if ((neg_q && acc_q != 0) || acc_q > {16'd0, maxv_q}) begin
                  fail_now = 1'b1; fk = KIND_RANGE;
                end else begin
                  dval_d = acc_q[15:0]; pend_d = eof_q; st_d = ST_DIV;
                end
              end
            end
          endcase
        end
        if (fail_now) begin
          ov_d = 1'b1; okind_d = fk; osmp_d = '0; olast_d = 1'b0; st_d = ST_STOP;
        end else if (rdy) begin
          st_d = ST_WAIT;
        end
      end
      ST_DIV: begin
        if (!drsp.done) begin
          if (st_q == ST_DIV && !dreq.start && nbits_q == 4'd15) begin
            dreq.start = 1'b0;
          end
        end else begin
          osmp_d = drsp.quotient; st_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_SAMPLE;
          left_d = (left_q != 0) ? left_q - 26'd1 : left_q;
          olast_d = (left_d == 0);
          if (olast_d) st_d = ST_STOP;
          else if (pend_q) begin st_d = ST_STOP; pend_d = 1'b0; end
          else st_d = ST_IDLE;
        end
      end
      ST_BITS: begin
        if (bidx_q == nbits_q) st_d = ST_IDLE;
        else if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_SAMPLE;
          osmp_d = byte_q[3'(4'd7 - bidx_q)] ? 8'd0 : 8'd255;
          left_d = (left_q != 0) ? left_q - 26'd1 : left_q;
          olast_d = (left_d == 0);
          bidx_d = bidx_q + 4'd1;
          if (olast_d) st_d = ST_STOP;
        end
      end
      ST_STOP: begin
        // End of file right after a closing text sample reports once more.
        if (pend_q && out_free) begin
          ov_d = 1'b1; okind_d = KIND_EOF; osmp_d = '0; olast_d = 1'b0; pend_d = 1'b0;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // Launch the divide for a scaled sample when entering the divide state.
    if (st_q != ST_DIV && st_d == ST_DIV) begin
      dreq.start    = 1'b1;
      dreq.dividend = 24'({8'd0, dval_d} * 24'd255 + {9'd0, maxv_q[15:1]});
      dreq.divisor  = maxv_q;
    end
  end

  // Pending error from a text sample closed by end of file must survive ST_WAIT.
  logic pend_hold;
  assign pend_hold = (st_q == ST_WAIT && out_free && pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ph_q <= PH_MAGIC; fmt_q <= '0; acc_q <= '0; neg_q <= 1'b0;
      cmt_q <= 1'b0; nst_q <= NUM_SKIP; wid_q <= '0; hgt_q <= '0; maxv_q <= '0;
      left_q <= '0; col_q <= '0; mask_q <= 1'b0; ov_q <= 1'b0; pend_q <= 1'b0;
      nbits_q <= '0; bidx_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; fmt_q <= fmt_d; acc_q <= acc_d; neg_q <= neg_d;
      cmt_q <= cmt_d; nst_q <= nst_d; wid_q <= wid_d; hgt_q <= hgt_d; maxv_q <= maxv_d;
      left_q <= left_d; col_q <= col_d; ov_q <= ov_d;
      pend_q <= pend_hold ? !olast_d : pend_d;
      nbits_q <= nbits_d; bidx_q <= bidx_d;
      if (cfg_valid && cfg_ready) mask_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; eof_q <= eof_d; dval_q <= dval_d;
    okind_q <= okind_d; osmp_q <= osmp_d; olast_q <= olast_d;
  end

  // A byte is taken in the idle state once the output register is free; after a halt,
  // every byte is taken and dropped.
  assign cfg_ready      = 1'b1;
  assign in_stall       = ((st_q != ST_IDLE) || !out_free) && (st_q != ST_STOP);
  assign out_valid      = ov_q;
  assign kind_o         = okind_q;
  assign sample_o       = osmp_q;
  assign last_sample_o  = olast_q;
  assign image_width_o  = wid_q;
  assign image_height_o = hgt_q;
  assign is_color_o     = color;

endmodule

>>> rtl/pnm_checker.sv
// Port-level checker for the anymap stream decoder, bound to the top level.
`timescale 1ns / 1ps
module pnm_checker import pnm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind_o,
  input logic [7:0] sample_o,
  input logic       last_sample_o
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(kind_o) && $stable(sample_o))
    else $error("stalled result changed");

  // Error results carry no sample.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind_o != KIND_SAMPLE |-> sample_o == 8'd0 && !last_sample_o)
    else $error("error result carries sample data");

  // Kind stays in its defined range.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> kind_o <= KIND_COLOR)
    else $error("undefined result kind");

endmodule

bind pnm_stream_decoder pnm_checker u_pnm_checker (
  .clk_i, .rst_ni, .out_valid, .out_stall, .kind_o, .sample_o, .last_sample_o
);

>>> tb/sv/pnm_stream_checker.sv
// Checker that predicts the decoder's results from the accepted bytes and compares them.
`timescale 1ns / 1ps
module pnm_stream_checker import pnm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind_o,
  input  logic [7:0]  sample_o,
  input  logic        last_sample_o,
  input  logic [12:0] image_width_o,
  input  logic [12:0] image_height_o,
  input  logic        is_color_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  localparam int unsigned MaxDim    = MaxDimDefault;
  localparam int unsigned MaxSample = MaxSampleDefault;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_DIGIT, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
    PH_TEXT_BITS, PH_RAW_BITS, PH_TEXT_MAP, PH_RAW_MAP, PH_DONE, PH_HALT
  } parse_phase_e;

  typedef enum logic [1:0] {NR_MORE, NR_DONE, NR_ERR} number_status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  sample;
    logic        last;
    logic [12:0] width;
    logic [12:0] height;
    logic        color;
  } pixel_result_t;

  pixel_result_t expected_results[$];

  // Shadow of the decoder state.
  logic         mask_color;
  parse_phase_e phase;
  logic [2:0]   fmt_digit;
  logic [31:0]  accum;
  logic         negative;
  logic         in_comment;
  logic [1:0]   number_stage;
  logic [12:0]  width_q;
  logic [12:0]  height_q;
  logic [15:0]  maxval_q;
  longint unsigned samples_left;
  logic [12:0]  column;

  int fail_count;
  int results_seen;
  int pending_count;

  assign fail_count_o   = fail_count;
  assign pending_o      = pending_count;
  assign results_seen_o = results_seen;

  function automatic logic color_format();
    return (fmt_digit == 3'd3) || (fmt_digit == 3'd6);
  endfunction

  function automatic void push_result(logic [2:0] kind, logic [7:0] s, logic last);
    pixel_result_t r;
    r.kind   = kind;
    r.sample = s;
    r.last   = last;
    r.width  = width_q;
    r.height = height_q;
    r.color  = color_format();
    expected_results.push_back(r);
  endfunction

  function automatic void halt_with(logic [2:0] kind);
    push_result(kind, 8'd0, 1'b0);
    phase = PH_HALT;
  endfunction

  function automatic void emit_sample(logic [7:0] s);
    logic last;
    last = 1'b0;
    if (samples_left > 0) samples_left--;
    if (samples_left == 0) begin
      last  = 1'b1;
      phase = PH_DONE;
    end
    push_result(KIND_SAMPLE, s, last);
  endfunction

  function automatic logic [7:0] scale_sample(logic [31:0] v);
    logic [31:0] q;
    if (maxval_q == 0) return 8'd0;
    q = (v * 32'd255 + {17'd0, maxval_q[15:1]}) / {16'd0, maxval_q};
    return q[7:0];
  endfunction

  function automatic logic value_in_range(logic [31:0] hi);
    if (negative && accum != 0) return 1'b0;
    return (accum >= 1) && (accum <= hi);
  endfunction

  // One byte of a header integer or a text sample.
  function automatic number_status_e feed_number(logic [7:0] c, logic eof);
    logic [31:0] d, limit;
    if (number_stage == NUM_SKIP) begin
      if (eof) return NR_ERR;
      if (is_space(c)) return NR_MORE;
      if (c == CH_HASH) begin
        in_comment = 1'b1;
        return NR_MORE;
      end
      negative = 1'b0;
      if (c == CH_MINUS) begin
        negative     = 1'b1;
        number_stage = NUM_SIGN;
        return NR_MORE;
      end
      if (is_digit(c)) begin
        accum        = {24'd0, c} - 32'd48;
        number_stage = NUM_DIGIT;
        return NR_MORE;
      end
      return NR_ERR;
    end
    if (number_stage == NUM_SIGN) begin
      if (!eof && is_digit(c)) begin
        accum        = {24'd0, c} - 32'd48;
        number_stage = NUM_DIGIT;
        return NR_MORE;
      end
      return NR_ERR;
    end
    if (!eof && is_digit(c)) begin
      d     = {24'd0, c} - 32'd48;
      limit = negative ? 32'h8000_0000 : 32'h7fff_ffff;
      if (accum > (limit - d) / 32'd10) return NR_ERR;
      accum = accum * 32'd10 + d;
      return NR_MORE;
    end
    if (!eof && c == CH_HASH) in_comment = 1'b1;
    number_stage = NUM_SKIP;
    return NR_DONE;
  endfunction

  function automatic void start_raster();
    samples_left = longint'(width_q) * longint'(height_q) * (color_format() ? 3 : 1);
    column = '0;
    case (fmt_digit)
      3'd1: phase = PH_TEXT_BITS;
      3'd4: phase = PH_RAW_BITS;
      3'd2, 3'd3: phase = PH_TEXT_MAP;
      default: phase = PH_RAW_MAP;
    endcase
  endfunction

  // Works out the results that one accepted byte causes.
  function automatic void predict_byte(logic [7:0] c, logic eof);
    number_status_e st;
    logic [12:0] n;
    if (phase == PH_DONE || phase == PH_HALT) return;
    if (in_comment) begin
      if (!eof) begin
        if (c == CH_LF || c == CH_CR) in_comment = 1'b0;
        return;
      end
      in_comment = 1'b0;
    end
    case (phase)
      PH_MAGIC: begin
        if (eof || c != CH_P) halt_with(KIND_MAGIC);
        else phase = PH_DIGIT;
      end
      PH_DIGIT: begin
        if (eof || c < CH_ONE || c > CH_SIX) begin
          halt_with(KIND_MAGIC);
        end else begin
          fmt_digit = 3'(c - CH_ZERO);
          if (color_format() && mask_color) begin
            halt_with(KIND_COLOR);
          end else begin
            phase        = PH_WIDTH;
            number_stage = NUM_SKIP;
          end
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        st = feed_number(c, eof);
        if (st == NR_ERR) begin
          halt_with(KIND_SYNTAX);
          return;
        end
        if (st == NR_DONE) begin
          if (phase == PH_WIDTH) begin
            if (!value_in_range(MaxDim)) begin
              halt_with(KIND_SYNTAX);
              return;
            end
            width_q = accum[12:0];
            phase   = PH_HEIGHT;
          end else if (phase == PH_HEIGHT) begin
            if (!value_in_range(MaxDim)) begin
              halt_with(KIND_SYNTAX);
              return;
            end
            height_q = accum[12:0];
            if (fmt_digit == 3'd1 || fmt_digit == 3'd4) start_raster();
            else phase = PH_MAXVAL;
          end else begin
            if (!value_in_range(MaxSample)) begin
              halt_with(KIND_SYNTAX);
              return;
            end
            maxval_q = accum[15:0];
            start_raster();
          end
        end
        if (eof) halt_with(phase <= PH_MAXVAL ? KIND_SYNTAX : KIND_EOF);
      end
      PH_TEXT_BITS: begin
        if (eof) halt_with(KIND_EOF);
        else if (c == CH_ONE) emit_sample(8'd0);
        else if (c == CH_ZERO) emit_sample(8'd255);
      end
      PH_RAW_BITS: begin
        if (eof) begin
          halt_with(KIND_EOF);
        end else begin
          n = width_q - column;
          if (n > 8) n = 8;
          for (int i = 0; i < n && phase == PH_RAW_BITS; i++)
            emit_sample(c[7-i] ? 8'd0 : 8'd255);
          column = column + n;
          if (column >= width_q) column = '0;
        end
      end
      PH_RAW_MAP: begin
        if (eof) halt_with(KIND_EOF);
        else emit_sample(scale_sample({24'd0, c}));
      end
      PH_TEXT_MAP: begin
        if (eof && number_stage != NUM_DIGIT) begin
          halt_with(KIND_EOF);
          return;
        end
        st = feed_number(c, eof);
        if (st == NR_ERR) begin
          halt_with(KIND_RANGE);
          return;
        end
        if (st == NR_DONE) begin
          if ((negative && accum != 0) || accum > {16'd0, maxval_q}) begin
            halt_with(KIND_RANGE);
            return;
          end
          emit_sample(scale_sample(accum));
        end
        if (eof && phase == PH_TEXT_MAP) halt_with(KIND_EOF);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare finished transfers first, then predict from new input and config transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      mask_color    = 1'b0;
      phase         = PH_MAGIC;
      fmt_digit     = '0;
      accum         = '0;
      negative      = 1'b0;
      in_comment    = 1'b0;
      number_stage  = NUM_SKIP;
      width_q       = '0;
      height_q      = '0;
      maxval_q      = '0;
      samples_left  = 0;
      column        = '0;
      fail_count    = 0;
      results_seen  = 0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, kind", kind_o, -1);
        end else begin
          want = expected_results.pop_front();
          if (kind_o != want.kind) report_mismatch("kind", kind_o, want.kind);
          if (sample_o != want.sample) report_mismatch("sample", sample_o, want.sample);
          if (last_sample_o != want.last)
            report_mismatch("last_sample", last_sample_o, want.last);
          if (image_width_o != want.width)
            report_mismatch("image_width", image_width_o, want.width);
          if (image_height_o != want.height)
            report_mismatch("image_height", image_height_o, want.height);
          if (is_color_o != want.color) report_mismatch("is_color", is_color_o, want.color);
        end
      end
      if (cfg_valid && cfg_ready) mask_color = cfg_data;
      if (in_valid && !in_stall) predict_byte(data_byte_i, end_of_file_i);
      pending_count = expected_results.size();
    end
  end

endmodule

>>> tb/sv/pnm_stream_decoder_test.sv
// Testbench top that feeds a raw gray or color map file to the decoder and gives the verdict.
`timescale 1ns / 1ps
module pnm_stream_decoder_test;

  localparam int CycleLimit = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte_i;
  logic        end_of_file_i;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  kind_o;
  logic [7:0]  sample_o;
  logic        last_sample_o;
  logic [12:0] image_width_o;
  logic [12:0] image_height_o;
  logic        is_color_o;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          cycle_count;
  int          bytes_sent;
  int          burst_left;

  pnm_stream_decoder DUT (.*);

  pnm_stream_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_stall,
    .data_byte_i, .end_of_file_i, .out_valid, .out_stall, .kind_o, .sample_o,
    .last_sample_o, .image_width_o, .image_height_o, .is_color_o,
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls in four modes that take turns as the cycle count advances: none, sparse, heavy, long runs.
  initial out_stall = 1'b0;
  always @(negedge clk_i) begin
    case ((cycle_count / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_count % 16) < 9);
    endcase
  end

  // Offers one byte at a falling edge and holds it until the transfer.
  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid      <= 1'b1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Lets the decoder drain everything expected, then a little longer.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_mask(logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic        color;
    int          w;
    int          h;
    int          maxval;
    int          nsamples;
    logic [7:0]  corner_bytes[$];
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    in_valid      = 1'b0;
    data_byte_i   = 8'd0;
    end_of_file_i = 1'b0;
    bytes_sent    = 0;
    burst_left    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    color  = $urandom_range(0, 1);
    w      = color ? 8 : 16;
    h      = color ? 10 : 15;
    nsamples = w * h * (color ? 3 : 1);
    case ($urandom_range(0, 3))
      0: maxval = 1;
      1: maxval = 255;
      2: maxval = 65535;
      default: maxval = $urandom_range(2, 254);
    endcase

    // Header with comments, varied whitespace, a leading zero and an integer closed by a hash.
    write_mask(1'b1);
    send_text("P");
    wait_idle();
    write_mask(color ? 1'b0 : 1'b1);
    send_text(color ? "6" : "5");
    send_text("# anymap\r \t0");
    send_text($sformatf("%0d#w\n", w));
    send_text($sformatf("\v%0d", h));
    send_byte(8'd0, 1'b0);
    send_text($sformatf("%0d\n", maxval));

    // Raster: corner values first, then random bytes.
    corner_bytes = '{8'd0, 8'd255, 8'd1, 8'd254, 8'(maxval), 8'(maxval + 1), 8'h55, 8'haa};
    for (int i = 0; i < nsamples; i++) begin
      if (i < corner_bytes.size()) send_byte(corner_bytes[i], 1'b0);
      else send_byte(8'($urandom_range(0, 255)), 1'b0);
      // Hold off once mid-raster until every expected result has come.
      if (i == nsamples / 2) begin
        wait_idle();
        write_mask(color ? 1'b1 : 1'b0);
      end
    end
    // The end of file after a finished image is ignored.
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Decoded a raw %s map, %0dx%0d, maxval %0d: %0d bytes in, %0d results checked.",
             color ? "color" : "gray", w, h, maxval, bytes_sent, results_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
